// File: hdl/xrr_pkg.sv
// Shared types and constants for the ranged xorwow generator.
// No dependencies; every other file in hdl/ imports this package.
package xrr_pkg;

    localparam int BOUND_WIDTH = 16;
    localparam int RAW_W       = 32;
    localparam int SEED_COUNT  = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int SIZE_W      = BOUND_WIDTH + 1;
    localparam int CNT_W       = $clog2(RAW_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RAW_W-1:0] WEYL_STEP = 32'd362437;

    localparam logic [RAW_W-1:0] SEED_RESET [SEED_COUNT] = '{
        32'd123456789, 32'd362436069, 32'd521288629, 32'd88675123, 32'd5783321
    };

    typedef enum logic {
        FUNC_DRAW   = 1'b0,
        FUNC_RELOAD = 1'b1
    } func_t;

    typedef struct packed {
        func_t                  func;
        logic [BOUND_WIDTH-1:0] lower;
        logic [BOUND_WIDTH-1:0] upper;
    } in_word_t;

    typedef struct packed {
        logic [BOUND_WIDTH-1:0] value;
        logic [RAW_W-1:0]       raw_word;
        logic                   range_error;
    } out_word_t;

    // One classified job handed from the front end to the reduction unit.
    typedef struct packed {
        logic                   bypass;
        logic                   err;
        logic [RAW_W-1:0]       raw;
        logic [BOUND_WIDTH-1:0] lower;
        logic [SIZE_W-1:0]      size;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// File: hdl/xorwow_ranged_random_core.sv
// Top level of the ranged xorwow generator: front end, job queue, reduction unit.
// Depends on xrr_pkg, xrr_front, xrr_queue and xrr_back.
//
//   port group   direction  handshake            word
//   req          in         req_valid/req_stall  in_word_t (func, lower, upper)
//   rsp          out        rsp_valid/rsp_stall  out_word_t (value, raw_word, range_error)
//   cfg          in         cfg_we               seed register index and data
//
// A draw goes from queue head to result through a load, 32 steps of the bit-serial
// modulo unit and a result state; a reload or a range error skips the modulo steps.
// The generator state advances when the word is accepted; the queue holds two jobs.
// rsp_stall holds the result and the reduction unit; req_stall rises only when the
// queue is full. Reset loads the seed reset values and clears the Weyl counter.
module xorwow_ranged_random_core
    import xrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  in_word_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output out_word_t            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data
);

    logic   push;
    logic   pop;
    job_t   push_job;
    job_t   head;
    qstat_t qstat;

    xrr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .job       (push_job)
    );

    xrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    xrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job popped from an empty queue");

    a_pop_after_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !rsp_valid)
        else $error("new job taken while a result is pending");

    a_error_job_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_job.err |-> push_job.bypass)
        else $error("range error job sent to the modulo unit");

endmodule

// File: hdl/xrr_front.sv
// Front end: seed registers, xorwow state and Weyl counter, job classification.
// Depends on xrr_pkg.
module xrr_front
    import xrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  in_word_t             req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    input  qstat_t               qstat,
    output logic                 push,
    output job_t                 job
);

    logic [RAW_W-1:0] seed_reg  [SEED_COUNT];
    logic [RAW_W-1:0] shift_reg [SEED_COUNT];
    logic [RAW_W-1:0] weyl_reg;
    logic [RAW_W-1:0] weyl_next;
    logic [RAW_W-1:0] mix_t;
    logic [RAW_W-1:0] mix_s;
    logic [RAW_W-1:0] mixed;
    logic [RAW_W-1:0] raw;
    logic             is_reload;
    logic             bad_range;

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;
    assign is_reload = (req.func == FUNC_RELOAD);
    assign bad_range = (req.upper < req.lower);

    always_comb
    begin
        mix_t     = shift_reg[4];
        mix_s     = shift_reg[0];
        mix_t     = mix_t ^ (mix_t >> 2);
        mix_t     = mix_t ^ (mix_t << 1);
        mixed     = mix_t ^ mix_s ^ (mix_s << 4);
        weyl_next = weyl_reg + WEYL_STEP;
        raw       = mixed + weyl_next;
    end

    always_comb
    begin
        job.bypass = is_reload || bad_range;
        job.err    = !is_reload && bad_range;
        job.raw    = is_reload ? '0 : raw;
        job.lower  = req.lower;
        job.size   = {1'b0, req.upper} - {1'b0, req.lower} + SIZE_W'(1);
    end

    // Seed registers: indexes past the last seed are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEED_COUNT; i++)
                seed_reg[i] <= SEED_RESET[i];
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < SEED_COUNT; i++)
                if (cfg_index == CFG_IDX_W'(i))
                    seed_reg[i] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEED_COUNT; i++)
                shift_reg[i] <= SEED_RESET[i];
            weyl_reg <= '0;
        end
        else if (push)
        begin
            if (is_reload)
            begin
                for (int i = 0; i < SEED_COUNT; i++)
                    shift_reg[i] <= seed_reg[i];
                weyl_reg <= '0;
            end
            else
            begin
                // advance the ring, mixed word enters at the head
                shift_reg[4] <= shift_reg[3];
                shift_reg[3] <= shift_reg[2];
                shift_reg[2] <= shift_reg[1];
                shift_reg[1] <= shift_reg[0];
                shift_reg[0] <= mixed;
                weyl_reg     <= weyl_next;
            end
        end
    end

endmodule

// File: hdl/xrr_queue.sv
// Short job queue between the front end and the reduction unit.
// Depends on xrr_pkg.
module xrr_queue
    import xrr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    input  logic   pop,
    output job_t   head,
    output qstat_t qstat
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hdl/xrr_back.sv
// Back end: bit-serial modulo of the raw word by the range size, result register.
// Depends on xrr_pkg.
module xrr_back
    import xrr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  qstat_t    qstat,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp
);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [RAW_W-1:0]       dividend_reg;
    logic [BOUND_WIDTH-1:0] rem_reg;
    logic [BOUND_WIDTH-1:0] rem_next;
    logic [SIZE_W-1:0]      size_reg;
    logic [BOUND_WIDTH-1:0] lower_reg;
    logic [RAW_W-1:0]       raw_reg;
    logic                   err_reg;
    logic [SIZE_W-1:0]      trial;
    logic                   last_step;
    logic                   step;

    assign last_step = (cnt_reg == CNT_W'(RAW_W - 1));

    // Restoring step: remainder stays below size, so trial stays below twice size.
    always_comb
    begin
        trial = {rem_reg, dividend_reg[RAW_W-1]};
        if (trial >= size_reg)
            rem_next = BOUND_WIDTH'(trial - size_reg);
        else
            rem_next = trial[BOUND_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                    state_next = head.bypass ? BK_DONE : BK_DIV;
            end
            BK_DIV:
            begin
                if (last_step)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!rsp_stall)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        step      = 1'b0;
        rsp_valid = 1'b0;
        case (state_reg)
            BK_IDLE: pop       = !qstat.empty;
            BK_DIV:  step      = 1'b1;
            BK_DONE: rsp_valid = 1'b1;
            default:
            begin
                pop       = 1'b0;
                step      = 1'b0;
                rsp_valid = 1'b0;
            end
        endcase
    end

    assign rsp.value       = lower_reg + rem_reg;
    assign rsp.raw_word    = raw_reg;
    assign rsp.range_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dividend_reg <= head.raw;
            raw_reg      <= head.raw;
            lower_reg    <= head.lower;
            size_reg     <= head.size;
            err_reg      <= head.err;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (step)
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_reg + 1'b1;
        end
    end

endmodule
